// File: rtl/euravg_pkg.sv
// Shared constants, codes and types for the encoder unwrap and rate average block.
package euravg_pkg;

    localparam int SAMPLE_W     = 13;
    localparam int STEP_W       = 14;
    localparam int TURN_W       = 16;
    localparam int POS_W        = 30;
    localparam int ANGLE_W      = 33;
    localparam int DELTA45_W    = 20;

    localparam int RING_DEPTH_DEF = 8;

    localparam logic [SAMPLE_W-1:0] THRESH_RESET = 13'd7500;
    localparam logic [STEP_W-1:0]   REV_COUNTS   = 14'd8192;
    localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sd32767;

    localparam logic FUNC_CAPTURE = 1'b0;
    localparam logic FUNC_PROCESS = 1'b1;

    // Per-item values produced by the front end for the output stage
    typedef struct packed {
        logic signed [POS_W-1:0]  position;
        logic signed [STEP_W-1:0] delta;
        logic signed [STEP_W-1:0] step;
        logic signed [TURN_W-1:0] turns;
    } front_res_t;

endpackage

// File: rtl/euravg_cell.sv
// One cell of the step history chain: holds a step and hands it on when shifted.
module euravg_cell
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     shift_en,
    input  logic signed [euravg_pkg::STEP_W-1:0]     step_in,
    output logic signed [euravg_pkg::STEP_W-1:0]     step_out
);

    logic signed [euravg_pkg::STEP_W-1:0] step_reg;
    logic signed [euravg_pkg::STEP_W-1:0] step_next;

    always_comb
    begin
        step_next = shift_en ? step_in : step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign step_out = step_reg;

endmodule

// File: rtl/euravg_front.sv
// Unwrap front end: previous sample, bias, turn count, step chain and running sum.
module euravg_front
#(
    parameter int RING_DEPTH = euravg_pkg::RING_DEPTH_DEF,
    parameter int SUM_W      = euravg_pkg::SAMPLE_W + $clog2(RING_DEPTH) + 1
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic                                 func,
    input  logic [euravg_pkg::SAMPLE_W-1:0]      raw_sample,
    input  logic                                 cfg_wr_en,
    input  logic [euravg_pkg::SAMPLE_W-1:0]      cfg_wr_data,
    output euravg_pkg::front_res_t               res,
    output logic signed [SUM_W-1:0]              step_sum
);

    localparam int STEP_W = euravg_pkg::STEP_W;
    localparam int TURN_W = euravg_pkg::TURN_W;
    localparam int POS_W  = euravg_pkg::POS_W;

    logic [euravg_pkg::SAMPLE_W-1:0] thresh_reg;
    logic [euravg_pkg::SAMPLE_W-1:0] prev_reg;
    logic [euravg_pkg::SAMPLE_W-1:0] prev_next;
    logic [euravg_pkg::SAMPLE_W-1:0] bias_reg;
    logic [euravg_pkg::SAMPLE_W-1:0] bias_next;
    logic signed [TURN_W-1:0]        turns_reg;
    logic signed [TURN_W-1:0]        turns_next;
    logic signed [SUM_W-1:0]         sum_reg;
    logic signed [SUM_W-1:0]         sum_next;

    logic signed [STEP_W:0]          diff;
    logic signed [STEP_W:0]          thr;
    logic signed [STEP_W-1:0]        step;
    logic                            is_process;
    logic                            shift_en;

    logic signed [STEP_W-1:0]        chain [RING_DEPTH+1];

    assign is_process = (func == euravg_pkg::FUNC_PROCESS);
    assign shift_en   = accept && is_process;

    // Row of cells: the newest step enters at the head, the oldest leaves at the tail
    assign chain[0] = step;
    for (genvar i = 0; i < RING_DEPTH; i++)
    begin : g_cell
        euravg_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .step_in  (chain[i]),
            .step_out (chain[i+1])
        );
    end

    always_comb
    begin
        diff = $signed({2'b00, raw_sample}) - $signed({2'b00, prev_reg});
        thr  = $signed({2'b00, thresh_reg});
        turns_next = turns_reg;
        step       = '0;
        prev_next  = prev_reg;
        bias_next  = bias_reg;
        sum_next   = sum_reg;
        if (is_process)
        begin
            // Large jump backwards is a forward wrap across zero, and vice versa
            if (diff < -thr)
            begin
                if (turns_reg < euravg_pkg::TURN_MAX)
                begin
                    turns_next = turns_reg + 16'sd1;
                end
                step = STEP_W'(diff + $signed({1'b0, euravg_pkg::REV_COUNTS}));
            end
            else if (diff > thr)
            begin
                if (turns_reg > -euravg_pkg::TURN_MAX)
                begin
                    turns_next = turns_reg - 16'sd1;
                end
                step = STEP_W'(diff - $signed({1'b0, euravg_pkg::REV_COUNTS}));
            end
            else
            begin
                step = STEP_W'(diff);
            end
            prev_next = raw_sample;
            sum_next  = sum_reg + SUM_W'(step) - SUM_W'(chain[RING_DEPTH]);
        end
        else
        begin
            prev_next = raw_sample;
            bias_next = raw_sample;
        end
    end

    always_comb
    begin
        res.step  = step;
        res.turns = turns_next;
        res.delta = $signed({1'b0, raw_sample}) - $signed({1'b0, bias_next});
        if (is_process)
        begin
            // Sign-extend the turn count above the sample bits
            res.position = $signed({turns_next[TURN_W-1], turns_next, raw_sample});
        end
        else
        begin
            res.position = $signed({{(POS_W - euravg_pkg::SAMPLE_W){1'b0}}, raw_sample});
        end
    end

    assign step_sum = sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= euravg_pkg::THRESH_RESET;
            prev_reg   <= '0;
            bias_reg   <= '0;
            turns_reg  <= '0;
            sum_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thresh_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                prev_reg  <= prev_next;
                bias_reg  <= bias_next;
                turns_reg <= turns_next;
                sum_reg   <= sum_next;
            end
        end
    end

endmodule

// File: rtl/encoder_unwrap_rate_average.sv
// Top level of the multi-turn encoder unwrap with moving-average step rate.
//
// Input channel: in_valid / in_stall with func and raw_sample. func capture
// stores the sample as bias and previous sample; func process unwraps it.
// Output channel: out_valid / out_stall with unwrapped_position, angle_q8,
// step_rate, mean_rate and turn_count, one result per item, in order.
// Configuration: cfg_wr_en / cfg_wr_data write the wrap threshold; write it
// only while no item is in flight.
// Pipeline: two stages (unwrap and step history, then angle and mean); an accepted
// item is registered in the internal stage, then in the output registers.
// Throughput: one item per cycle while the output is not stalled; the turn count,
// previous sample and running sum close their loop at acceptance.
// The step history is a row of RING_DEPTH cells shifted on each process item.
// Reset clears the turn count, bias, previous sample, history and sum and
// loads the threshold with 7500; the block accepts items from the first
// cycle after reset.
// When the receiver stalls, the result holds; one more item is taken into
// the internal stage, then in_stall rises until the output drains.
module encoder_unwrap_rate_average
#(
    parameter int RING_DEPTH = euravg_pkg::RING_DEPTH_DEF
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic                                      func,
    input  logic [euravg_pkg::SAMPLE_W-1:0]           raw_sample,
    input  logic                                      cfg_wr_en,
    input  logic [euravg_pkg::SAMPLE_W-1:0]           cfg_wr_data,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [euravg_pkg::POS_W-1:0]       unwrapped_position,
    output logic signed [euravg_pkg::ANGLE_W-1:0]     angle_q8,
    output logic signed [euravg_pkg::STEP_W-1:0]      step_rate,
    output logic signed [euravg_pkg::STEP_W-1:0]      mean_rate,
    output logic signed [euravg_pkg::TURN_W-1:0]      turn_count
);

    localparam int SAMPLE_W  = euravg_pkg::SAMPLE_W;
    localparam int STEP_W    = euravg_pkg::STEP_W;
    localparam int ANGLE_W   = euravg_pkg::ANGLE_W;
    localparam int TURN_W    = euravg_pkg::TURN_W;
    localparam int DELTA45_W = euravg_pkg::DELTA45_W;
    localparam int DEPTH_LOG = $clog2(RING_DEPTH);
    localparam int MAG_W     = SAMPLE_W + DEPTH_LOG;
    localparam int SUM_W     = MAG_W + 1;
    localparam int RECIP_W   = MAG_W + 1;
    localparam int PROD_W    = MAG_W + RECIP_W;
    localparam int SHIFT     = MAG_W + DEPTH_LOG;
    localparam longint RECIP_VAL = ((64'sd1 <<< SHIFT) + RING_DEPTH - 1) / RING_DEPTH;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    logic                    accept;
    logic                    out_free;
    logic                    s1_adv;

    euravg_pkg::front_res_t  front_res;
    logic signed [SUM_W-1:0] front_sum;

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    euravg_pkg::front_res_t  s1_res_reg;
    logic signed [SUM_W-1:0] s1_sum_reg;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic signed [euravg_pkg::POS_W-1:0] pos_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic signed [ANGLE_W-1:0] angle_next;
    logic signed [STEP_W-1:0]  step_reg;
    logic signed [STEP_W-1:0]  mean_reg;
    logic signed [STEP_W-1:0]  mean_next;
    logic signed [TURN_W-1:0]  turns_reg;

    logic [MAG_W-1:0]          sum_mag;
    logic [PROD_W-1:0]         prod;
    logic [SAMPLE_W-1:0]       quot;
    logic signed [DELTA45_W-1:0] d20;
    logic signed [DELTA45_W-1:0] delta45;
    logic signed [ANGLE_W-1:0]   t33;
    logic signed [ANGLE_W-1:0]   turn_angle;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    euravg_front
    #(
        .RING_DEPTH (RING_DEPTH),
        .SUM_W      (SUM_W)
    )
    u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .func        (func),
        .raw_sample  (raw_sample),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res         (front_res),
        .step_sum    (front_sum)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Mean: divide the sum magnitude by the depth through a reciprocal, truncate toward zero
    always_comb
    begin
        sum_mag   = s1_sum_reg[SUM_W-1] ? MAG_W'(-s1_sum_reg) : MAG_W'(s1_sum_reg);
        prod      = PROD_W'(sum_mag) * PROD_W'(RECIP);
        quot      = prod[SHIFT +: SAMPLE_W];
        mean_next = s1_sum_reg[SUM_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    // Angle: floor(delta * 45 / 4) + turns * 92160, all by shifts and adds
    always_comb
    begin
        d20     = DELTA45_W'(s1_res_reg.delta);
        delta45 = (d20 <<< 5) + (d20 <<< 3) + (d20 <<< 2) + d20;
        t33     = ANGLE_W'(s1_res_reg.turns);
        turn_angle = (t33 <<< 16) + (t33 <<< 14) + (t33 <<< 13) + (t33 <<< 11);
        angle_next = ANGLE_W'(delta45 >>> 2) + turn_angle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= front_res;
            s1_sum_reg <= front_sum;
        end
        if (s1_adv)
        begin
            pos_reg   <= s1_res_reg.position;
            angle_reg <= angle_next;
            step_reg  <= s1_res_reg.step;
            mean_reg  <= mean_next;
            turns_reg <= s1_res_reg.turns;
        end
    end

    assign out_valid          = out_valid_reg;
    assign unwrapped_position = pos_reg;
    assign angle_q8           = angle_reg;
    assign step_rate          = step_reg;
    assign mean_rate          = mean_reg;
    assign turn_count         = turns_reg;

endmodule

// File: test/encoder_unwrap_rate_average_test.sv
// Self-checking testbench for the encoder unwrap and rate average block.
`timescale 1ns / 100ps

module encoder_unwrap_rate_average_test;

    localparam int SAMPLE_W    = euravg_pkg::SAMPLE_W;
    localparam int STEP_W      = euravg_pkg::STEP_W;
    localparam int TURN_W      = euravg_pkg::TURN_W;
    localparam int POS_W       = euravg_pkg::POS_W;
    localparam int ANGLE_W     = euravg_pkg::ANGLE_W;
    localparam logic [SAMPLE_W-1:0] THRESH_RESET = euravg_pkg::THRESH_RESET;
    localparam logic FUNC_CAPTURE = euravg_pkg::FUNC_CAPTURE;
    localparam logic FUNC_PROCESS = euravg_pkg::FUNC_PROCESS;

    localparam int RING        = euravg_pkg::RING_DEPTH_DEF;
    localparam int REV         = 8192;
    localparam int TURN_LIMIT  = 32767;
    localparam int TURN_ANGLE  = 92160;
    localparam int HOLD_CYCLES = 40;
    localparam int SETTLE      = 4;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic signed [POS_W-1:0]   position;
        logic signed [ANGLE_W-1:0] angle;
        logic signed [STEP_W-1:0]  step;
        logic signed [STEP_W-1:0]  mean;
        logic signed [TURN_W-1:0]  turns;
    } encoder_reading_t;

    // Tracks bias, previous sample, turn count and step history; holds the
    // readings still owed by the block.
    class unwrap_tracker;
        logic [SAMPLE_W-1:0] threshold;
        logic [SAMPLE_W-1:0] prev_sample;
        logic [SAMPLE_W-1:0] bias;
        int turns;
        int steps [RING];
        int slot;
        int step_sum;
        encoder_reading_t expected_readings [$];
        int errors, samples_seen, captures, turns_up, turns_down, limit_hits;

        function new();
            threshold   = THRESH_RESET;
            prev_sample = '0;
            bias        = '0;
            turns       = 0;
            slot        = 0;
            step_sum    = 0;
            foreach (steps[i])
                steps[i] = 0;
            errors       = 0;
            samples_seen = 0;
            captures     = 0;
            turns_up     = 0;
            turns_down   = 0;
            limit_hits   = 0;
        endfunction

        function void set_threshold(logic [SAMPLE_W-1:0] value);
            threshold = value;
        endfunction

        function void note_sample(logic f, logic [SAMPLE_W-1:0] s);
            encoder_reading_t r;
            int diff;
            int thr;
            int st;
            longint pos;
            longint delta;
            longint ang;
            samples_seen++;
            if (f == FUNC_CAPTURE)
            begin
                captures++;
                bias        = s;
                prev_sample = s;
                st          = 0;
                pos         = longint'(s);
            end
            else
            begin
                diff = int'(s) - int'(prev_sample);
                thr  = int'(threshold);
                if (diff < -thr)
                begin
                    turns_up++;
                    if (turns < TURN_LIMIT)
                        turns++;
                    else
                        limit_hits++;
                    st = diff + REV;
                end
                else if (diff > thr)
                begin
                    turns_down++;
                    if (turns > -TURN_LIMIT)
                        turns--;
                    else
                        limit_hits++;
                    st = diff - REV;
                end
                else
                    st = diff;
                prev_sample = s;
                step_sum += st - steps[slot];
                steps[slot] = st;
                slot = (slot + 1) % RING;
                pos = longint'(s) + longint'(turns) * REV;
            end
            // floor of delta * 45 / 4, then whole turns in Q8 degrees
            delta = longint'(s) - longint'(bias);
            ang   = ((delta * 45) >>> 2) + longint'(turns) * TURN_ANGLE;
            r.position = POS_W'(pos);
            r.angle    = ANGLE_W'(ang);
            r.step     = STEP_W'(st);
            r.mean     = STEP_W'(step_sum / RING);
            r.turns    = TURN_W'(turns);
            expected_readings.push_back(r);
        endfunction

        function void check_result(encoder_reading_t got);
            encoder_reading_t want;
            if (expected_readings.size() == 0)
            begin
                $error("result with no item outstanding: position %0d", got.position);
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            if (got.position !== want.position)
            begin
                $error("unwrapped_position: expected %0d, actual %0d",
                       want.position, got.position);
                errors++;
            end
            if (got.angle !== want.angle)
            begin
                $error("angle_q8: expected %0d, actual %0d", want.angle, got.angle);
                errors++;
            end
            if (got.step !== want.step)
            begin
                $error("step_rate: expected %0d, actual %0d", want.step, got.step);
                errors++;
            end
            if (got.mean !== want.mean)
            begin
                $error("mean_rate: expected %0d, actual %0d", want.mean, got.mean);
                errors++;
            end
            if (got.turns !== want.turns)
            begin
                $error("turn_count: expected %0d, actual %0d", want.turns, got.turns);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic func;
    logic [SAMPLE_W-1:0] raw_sample;
    logic cfg_wr_en;
    logic [SAMPLE_W-1:0] cfg_wr_data;
    logic out_valid;
    logic out_stall;
    logic signed [POS_W-1:0]   unwrapped_position;
    logic signed [ANGLE_W-1:0] angle_q8;
    logic signed [STEP_W-1:0]  step_rate;
    logic signed [STEP_W-1:0]  mean_rate;
    logic signed [TURN_W-1:0]  turn_count;

    unwrap_tracker sb;
    bit idling_on = 1'b1;
    logic hold_req = 1'b0;
    int cycles = 0;
    int settings_used = 1;

    encoder_unwrap_rate_average u_top
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .func               (func),
        .raw_sample         (raw_sample),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .unwrapped_position (unwrapped_position),
        .angle_q8           (angle_q8),
        .step_rate          (step_rate),
        .mean_rate          (mean_rate),
        .turn_count         (turn_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $error("run did not complete within %0d cycles", CYCLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_sample(func, raw_sample);
    end

    always @(posedge clk)
    begin : result_monitor
        encoder_reading_t seen;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.position = unwrapped_position;
            seen.angle    = angle_q8;
            seen.step     = step_rate;
            seen.mean     = mean_rate;
            seen.turns    = turn_count;
            sb.check_result(seen);
        end
    end

    // Receiver: random stall bursts, or one long hold when asked
    initial
    begin : receiver
        bit hold_taken;
        hold_taken = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(logic f, logic [SAMPLE_W-1:0] s);
        in_valid   <= 1'b1;
        func       <= f;
        raw_sample <= s;
        do @(posedge clk); while (in_stall);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Hold the sender until every owed reading has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.expected_readings.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_threshold(logic [SAMPLE_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_threshold(value);
        settings_used++;
    endtask

    // Capture, then a steady rotation with jitter and the odd glitch sample
    task automatic run_motion(int length, int vmax);
        int cur;
        int vel;
        cur = int'($urandom_range(0, REV - 1));
        vel = int'($urandom_range(0, 2 * vmax)) - vmax;
        send_item(FUNC_CAPTURE, SAMPLE_W'(cur));
        repeat (length)
        begin
            cur = (cur + vel + int'($urandom_range(0, 4)) - 2) & (REV - 1);
            if ($urandom_range(0, 19) == 0)
                send_item(FUNC_PROCESS, SAMPLE_W'($urandom_range(0, REV - 1)));
            else
                send_item(FUNC_PROCESS, SAMPLE_W'(cur));
        end
    endtask

    task automatic random_phase(int n);
        int done;
        int len;
        int vmax;
        done = 0;
        while (done < n)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_item($urandom_range(0, 3) != 0 ? FUNC_PROCESS : FUNC_CAPTURE,
                          SAMPLE_W'($urandom_range(0, REV - 1)));
                done++;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       vmax = 40;
                    1:       vmax = 1500;
                    default: vmax = REV - 1;
                endcase
                len = int'($urandom_range(4, 30));
                run_motion(len, vmax);
                done += len + 1;
            end
        end
    endtask

    // Step by one count per item so that every process item is a wrap;
    // captures restart the sweep without touching the turn count.
    task automatic run_sweep(bit upward, int count);
        int cur;
        cur = upward ? REV - 1 : 0;
        send_item(FUNC_CAPTURE, SAMPLE_W'(cur));
        repeat (count)
        begin
            if (cur == (upward ? 0 : REV - 1))
            begin
                cur = upward ? REV - 1 : 0;
                send_item(FUNC_CAPTURE, SAMPLE_W'(cur));
            end
            else
            begin
                cur = upward ? cur - 1 : cur + 1;
                send_item(FUNC_PROCESS, SAMPLE_W'(cur));
            end
        end
    endtask

    task automatic directed_items();
        send_item(FUNC_PROCESS, 13'd0);
        send_item(FUNC_PROCESS, 13'd8191);
        send_item(FUNC_PROCESS, 13'd0);
        // steps exactly at the threshold, then one count beyond it
        send_item(FUNC_PROCESS, 13'd7500);
        send_item(FUNC_PROCESS, 13'd0);
        send_item(FUNC_PROCESS, 13'd7501);
        send_item(FUNC_PROCESS, 13'd0);
        send_item(FUNC_CAPTURE, 13'd8191);
        send_item(FUNC_PROCESS, 13'd0);
        send_item(FUNC_PROCESS, 13'd4095);
        send_item(FUNC_PROCESS, 13'd8190);
        // capture with a nonzero turn count, then angles below the bias
        send_item(FUNC_CAPTURE, 13'h0AAA);
        send_item(FUNC_PROCESS, 13'd0);
        send_item(FUNC_PROCESS, 13'd1);
        send_item(FUNC_PROCESS, 13'd8191);
        send_item(FUNC_PROCESS, 13'h1555);
        send_item(FUNC_PROCESS, 13'h0AAA);
        send_item(FUNC_CAPTURE, 13'd0);
        send_item(FUNC_PROCESS, 13'd3);
    endtask

    initial
    begin
        sb = new();
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        func        <= FUNC_CAPTURE;
        raw_sample  <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();
        random_phase(60);

        write_threshold(13'd8191);
        random_phase(100);
        write_threshold(13'd0);
        random_phase(100);

        idling_on = 1'b0;
        write_threshold(13'd1);
        random_phase(100);
        idling_on = 1'b1;

        // fill the block against a long receiver hold
        write_threshold(13'd4096);
        idling_on = 1'b0;
        hold_req <= 1'b1;
        repeat (30)
            send_item(FUNC_PROCESS, SAMPLE_W'($urandom_range(0, REV - 1)));
        idling_on = 1'b1;
        random_phase(80);

        write_threshold(SAMPLE_W'($urandom_range(1, REV - 1)));
        random_phase(100);
        write_threshold(THRESH_RESET);
        random_phase(100);

        // a run of wraps each way, no idling from here on
        idling_on = 1'b0;
        write_threshold(13'd0);
        run_sweep(1'b1, 40);
        run_sweep(1'b0, 40);

        wait_idle();
        $display("Checked %0d items (%0d captures) over %0d threshold settings",
                 sb.samples_seen, sb.captures, settings_used);
        $display("Wraps: %0d forward, %0d back, %0d held at the turn limit",
                 sb.turns_up, sb.turns_down, sb.limit_hits);
        if (sb.errors == 0 && sb.expected_readings.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
